// ===== src/anxb_pkg.sv =====
// ----------------------------------------------------------------------------
// anxb_pkg: shared types and constants of the Annex B NAL unit splitter
// Holds the input and output word types, the scan state record and the
// limits that size the result buffer.
// ----------------------------------------------------------------------------
package anxb_pkg;

	// Most results one input word can cause.
	localparam int ResMax = 5;
	// Width of a result count or result index (0 to ResMax).
	localparam int ResCntW = $clog2(ResMax + 1);
	// Most zero bytes held back as a possible start code.
	localparam int PendMax = 3;
	localparam int PendW = $clog2(PendMax + 1);

	localparam logic [7:0] ZeroByte = 8'h00;
	localparam logic [7:0] CodeByte = 8'h01;

	typedef struct packed {
		logic [7:0]  in_byte;
		logic [63:0] buffer_pts;
		logic        last_in_buffer;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  nal_byte;
		logic        first_of_nal;
		logic        last_of_nal;
		logic        empty_nal;
		logic [63:0] nal_pts;
	} out_word_t;

	typedef out_word_t [ResMax-1:0] out_set_t;

	// Scan state carried from one input word to the next. The held-back
	// bytes are always zeros, so only their count is kept.
	typedef struct packed {
		logic [PendW-1:0] pending;
		logic [7:0]       held_byte;
		logic             held_valid;
		logic             inside_nal;
		logic             awaiting_first;
		logic [63:0]      current_pts;
	} scan_state_t;

endpackage

// ===== src/anxb_scan.sv =====
// ----------------------------------------------------------------------------
// anxb_scan: one step of the start code scan
// Takes the scan state and one input word and gives the next state and the
// list of result words that the input word causes, oldest first.
// ----------------------------------------------------------------------------
module anxb_scan (
	input  anxb_pkg::scan_state_t                 cur,
	input  anxb_pkg::in_word_t                    word,
	output anxb_pkg::scan_state_t                 nxt,
	output anxb_pkg::out_set_t                    res,
	output logic [anxb_pkg::ResCntW-1:0]          res_cnt
);

	logic                          is_code;
	logic                          eob;
	logic                          take_b;
	logic [anxb_pkg::ResCntW-1:0]  zeros;
	logic [anxb_pkg::ResCntW-1:0]  ntake;
	logic [7:0]                    tbyte;

	assign eob = word.last_in_buffer;
	assign is_code = (word.in_byte == anxb_pkg::CodeByte) &&
		(cur.pending >= anxb_pkg::PendW'(2));

	always_comb begin
		nxt = cur;
		res = '0;
		res_cnt = '0;
		zeros = '0;
		take_b = 1'b0;
		ntake = '0;
		tbyte = anxb_pkg::ZeroByte;
		if (is_code) begin
			// The code closes the open NAL, or marks it empty.
			if (cur.inside_nal) begin
				res[0].nal_pts = cur.current_pts;
				if (cur.held_valid) begin
					res[0].nal_byte = cur.held_byte;
					res[0].first_of_nal = cur.awaiting_first;
					res[0].last_of_nal = 1'b1;
				end else begin
					res[0].empty_nal = 1'b1;
				end
				res_cnt = anxb_pkg::ResCntW'(1);
			end
			nxt.inside_nal = ~eob;
			nxt.awaiting_first = ~eob;
			nxt.held_valid = 1'b0;
			nxt.held_byte = '0;
			nxt.pending = '0;
			nxt.current_pts = word.buffer_pts;
		end else begin
			if (word.in_byte == anxb_pkg::ZeroByte) begin
				if (cur.pending == anxb_pkg::PendW'(anxb_pkg::PendMax)) begin
					zeros = anxb_pkg::ResCntW'(1);
				end else begin
					nxt.pending = cur.pending + anxb_pkg::PendW'(1);
				end
				if (eob) begin
					zeros = zeros + anxb_pkg::ResCntW'(nxt.pending);
				end
			end else begin
				zeros = anxb_pkg::ResCntW'(cur.pending);
				take_b = 1'b1;
				nxt.pending = '0;
			end
			ntake = zeros + anxb_pkg::ResCntW'(take_b);
			// Each taken byte pushes the held byte out as a payload result.
			for (int i = 0; i < anxb_pkg::ResMax; i++) begin
				if (anxb_pkg::ResCntW'(i) < ntake) begin
					tbyte = (take_b && (anxb_pkg::ResCntW'(i) == ntake - anxb_pkg::ResCntW'(1)))
						? word.in_byte : anxb_pkg::ZeroByte;
					if (nxt.inside_nal) begin
						if (nxt.held_valid) begin
							res[res_cnt].nal_byte = nxt.held_byte;
							res[res_cnt].first_of_nal = nxt.awaiting_first;
							res[res_cnt].nal_pts = nxt.current_pts;
							res_cnt = res_cnt + anxb_pkg::ResCntW'(1);
							nxt.awaiting_first = 1'b0;
						end
						nxt.held_byte = tbyte;
						nxt.held_valid = 1'b1;
					end
				end
			end
			if (eob) begin
				if (nxt.inside_nal && nxt.held_valid) begin
					res[res_cnt].nal_byte = nxt.held_byte;
					res[res_cnt].first_of_nal = nxt.awaiting_first;
					res[res_cnt].last_of_nal = 1'b1;
					res[res_cnt].nal_pts = nxt.current_pts;
					res_cnt = res_cnt + anxb_pkg::ResCntW'(1);
				end
				nxt.pending = '0;
				nxt.held_byte = '0;
				nxt.held_valid = 1'b0;
				nxt.inside_nal = 1'b0;
				nxt.awaiting_first = 1'b0;
			end
		end
	end

endmodule

// ===== src/annexb_nal_unit_splitter_core.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_core: Annex B start code NAL unit splitter
// Splits an H.264 Annex B byte stream at its start codes and sends out the
// NAL payload bytes with first, last and empty marks and the buffer's
// timestamp.
//
//   channel  word type        valid       stall       direction
//   byte     anxb_pkg::in_word_t   byte_valid  byte_stall  into the block
//   nal      anxb_pkg::out_word_t  nal_valid   nal_stall   out of the block
//
// An accepted byte word sits in the input register, where the scan logic
// turns it into zero to five result words in one pass and loads them into
// a five-entry result buffer. The buffer hands out one result word per cycle
// while nal_stall is low; the input register takes a new byte word as its
// word is loaded, and the buffer's single output sets the pace. A byte word
// passes the input register and then the result buffer before its first
// result shows. Reset clears the scan state and empties both the input
// register and the result buffer. A stall on the nal channel holds the result
// buffer and, once the input register is full, shows up as byte_stall.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  anxb_pkg::in_word_t   byte_word,
	output logic                 nal_valid,
	input  logic                 nal_stall,
	output anxb_pkg::out_word_t  nal_word
);

	// Input register.
	logic                          valid_s1;
	anxb_pkg::in_word_t            word_s1;

	// Scan state kept between byte words of a buffer.
	anxb_pkg::scan_state_t         st_q;
	anxb_pkg::scan_state_t         st_nxt;

	// Result buffer: res_cnt_q entries loaded, res_idx_q of them sent.
	anxb_pkg::out_set_t            res_q;
	anxb_pkg::out_set_t            res_nxt;
	logic [anxb_pkg::ResCntW-1:0]  res_cnt_q;
	logic [anxb_pkg::ResCntW-1:0]  res_idx_q;
	logic [anxb_pkg::ResCntW-1:0]  res_cnt_nxt;

	logic                          out_take;
	logic                          buf_free;
	logic                          load;
	logic                          in_take;

	anxb_scan u_scan (
		.cur     (st_q),
		.word    (word_s1),
		.nxt     (st_nxt),
		.res     (res_nxt),
		.res_cnt (res_cnt_nxt)
	);

	assign nal_valid = (res_idx_q != res_cnt_q);
	assign out_take = nal_valid && !nal_stall;

	// The buffer can take the next set of results once it is empty or its
	// final word leaves in this cycle.
	assign buf_free = (res_idx_q == res_cnt_q) ||
		(out_take && (res_idx_q + anxb_pkg::ResCntW'(1) == res_cnt_q));
	assign load = valid_s1 && buf_free;

	assign byte_stall = valid_s1 && !buf_free;
	assign in_take = byte_valid && !byte_stall;

	always_comb begin
		nal_word = '0;
		if (res_idx_q < anxb_pkg::ResCntW'(anxb_pkg::ResMax)) begin
			nal_word = res_q[res_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= byte_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			res_cnt_q <= '0;
			res_idx_q <= '0;
		end else if (load) begin
			st_q <= st_nxt;
			res_cnt_q <= res_cnt_nxt;
			res_idx_q <= '0;
		end else if (out_take) begin
			res_idx_q <= res_idx_q + anxb_pkg::ResCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_nxt;
		end
	end

	// The send index never runs past the loaded count.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_idx_q <= res_cnt_q)
		else $error("result index past result count");

	// A byte word that causes results shows its first one next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (res_cnt_nxt != '0)) |=> nal_valid)
		else $error("loaded results not presented");

	// An empty NAL marker carries no byte and no first or last mark.
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(nal_valid && nal_word.empty_nal) |->
		(nal_word.nal_byte == '0 && !nal_word.first_of_nal && !nal_word.last_of_nal))
		else $error("empty NAL marker carries payload marks");

	// Without a held word in the input register the block never stalls.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("stall without a held byte word");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Annex B NAL unit splitter core
// Feeds byte words of whole access-unit buffers into the core and follows
// the start code scan byte by byte in a behavioral copy. Every nal word
// that leaves the core is checked against the oldest expected word.
// ----------------------------------------------------------------------------
module tb;

	// Longest run of cycles with no word moving on either channel.
	localparam int IdleLimit = 2000;
	// Cycles allowed after the last expected nal word.
	localparam int SettleCycles = 12;
	// Length of the receiver's long hold-off and the result count that starts it.
	localparam int HoldOffCycles = 90;
	localparam int HoldOffAfter = 60;

	typedef struct {
		anxb_pkg::in_word_t w;
		bit                 wait_drain;
	} feed_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                byte_valid = 1'b0;
	logic                byte_stall;
	anxb_pkg::in_word_t  byte_word = '0;
	logic                nal_valid;
	logic                nal_stall = 1'b0;
	anxb_pkg::out_word_t nal_word;

	annexb_nal_unit_splitter_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.nal_valid  (nal_valid),
		.nal_stall  (nal_stall),
		.nal_word   (nal_word)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Scan model. It mirrors the splitter's state: a window of the last
	// three bytes, a count of zeros held back as a possible start code, a
	// one-byte delay that lets the last mark of a NAL be known, and the
	// timestamp latched at the start code that opened the current NAL.
	// ------------------------------------------------------------------
	logic [23:0] scan_win = '0;
	logic [2:0]  zero_run = '0;
	logic [7:0]  delay_byte = '0;
	logic        delay_ok = 1'b0;
	logic        nal_open = 1'b0;
	logic        first_due = 1'b0;
	logic [63:0] nal_ts = '0;

	anxb_pkg::out_word_t nal_expect_q[$];
	feed_item_t          feed_q[$];

	task automatic emit_nal_word(input logic [7:0] b, input logic is_first,
			input logic is_last, input logic is_empty, input logic [63:0] ts);
		anxb_pkg::out_word_t w;
		w.nal_byte = b;
		w.first_of_nal = is_first;
		w.last_of_nal = is_last;
		w.empty_nal = is_empty;
		w.nal_pts = ts;
		nal_expect_q.push_back(w);
	endtask

	// A payload byte only counts once a start code has opened a NAL. The
	// byte before it leaves the delay now, since it is known not to be last.
	task automatic pass_payload(input logic [7:0] b);
		if (nal_open) begin
			if (delay_ok) begin
				emit_nal_word(delay_byte, first_due, 1'b0, 1'b0, nal_ts);
				first_due = 1'b0;
			end
			delay_byte = b;
			delay_ok = 1'b1;
		end
	endtask

	// The held-back zeros turned out not to be a start code: they are
	// payload after all, oldest first.
	task automatic release_zero_run();
		logic [23:0] shifted;
		while (zero_run > 0) begin
			shifted = scan_win >> (8 * (zero_run - 1));
			pass_payload(shifted[7:0]);
			zero_run = zero_run - 1'b1;
		end
	endtask

	// Every buffer is scanned on its own. The latched timestamp survives,
	// but it is only read inside a NAL, which always sets it first.
	task automatic clear_scan();
		scan_win = '0;
		zero_run = '0;
		delay_byte = '0;
		delay_ok = 1'b0;
		nal_open = 1'b0;
		first_due = 1'b0;
	endtask

	task automatic predict_nal_words(input anxb_pkg::in_word_t w);
		if (w.in_byte == anxb_pkg::CodeByte && zero_run >= 2) begin
			// A start code closes the open NAL. With nothing in the delay the
			// NAL had no payload at all, which gives a single empty marker.
			if (nal_open) begin
				if (delay_ok)
					emit_nal_word(delay_byte, first_due, 1'b1, 1'b0, nal_ts);
				else
					emit_nal_word(anxb_pkg::ZeroByte, 1'b0, 1'b0, 1'b1, nal_ts);
			end
			nal_open = 1'b1;
			first_due = 1'b1;
			delay_ok = 1'b0;
			delay_byte = '0;
			zero_run = '0;
			scan_win = '0;
			nal_ts = w.buffer_pts;
			// A code at the very end of the buffer opens nothing.
			if (w.last_in_buffer)
				clear_scan();
		end else begin
			if (w.in_byte == anxb_pkg::ZeroByte) begin
				// Beyond three zeros the oldest one belongs to the payload.
				if (zero_run >= anxb_pkg::PendMax) begin
					pass_payload(anxb_pkg::ZeroByte);
					zero_run = 3'(anxb_pkg::PendMax);
				end else begin
					zero_run = zero_run + 1'b1;
				end
				scan_win = {scan_win[15:0], anxb_pkg::ZeroByte};
			end else begin
				release_zero_run();
				pass_payload(w.in_byte);
				scan_win = {scan_win[15:0], w.in_byte};
			end
			if (w.last_in_buffer) begin
				release_zero_run();
				if (nal_open && delay_ok)
					emit_nal_word(delay_byte, first_due, 1'b1, 1'b0, nal_ts);
				clear_scan();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus building. Bytes are queued with their buffer's timestamp;
	// the final byte of each buffer carries the end mark. A queued word
	// may ask the sender to wait until every expected nal word has come.
	// ------------------------------------------------------------------
	bit drain_next = 1'b0;
	int buffers_built = 0;

	task automatic queue_byte(input logic [7:0] b, input logic [63:0] ts,
			input logic is_last);
		feed_item_t it;
		it.w.in_byte = b;
		it.w.buffer_pts = ts;
		it.w.last_in_buffer = is_last;
		it.wait_drain = drain_next;
		drain_next = 1'b0;
		feed_q.push_back(it);
	endtask

	// Payload bytes lean toward zeros and ones so that false and split
	// start codes turn up inside NALs.
	function automatic logic [7:0] pick_payload_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return anxb_pkg::ZeroByte;
		else if (r < 35)
			return anxb_pkg::CodeByte;
		else if (r < 40)
			return 8'hFF;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [63:0] pick_pts();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r < 3)
			return '1;
		else
			return {$urandom(), $urandom()};
	endfunction

	// Most buffers are well formed: optional leading junk, one to four
	// NALs each behind a 3-byte or 4-byte code (sometimes with an extra
	// zero), and now and then a trailing code. The rest are noise.
	task automatic build_random_buffer();
		logic [7:0]  bq[$];
		logic [63:0] ts;
		logic [63:0] ts_late;
		int          nals;
		int          zeros;
		int          plen;
		int          shift_at;
		bq = {};
		ts = pick_pts();
		ts_late = pick_pts();
		if ($urandom_range(0, 99) < 85) begin
			repeat ($urandom_range(0, 3))
				bq.push_back(8'($urandom_range(1, 255)));
			nals = $urandom_range(1, 4);
			for (int n = 0; n < nals; n++) begin
				zeros = $urandom_range(2, 4);
				repeat (zeros)
					bq.push_back(anxb_pkg::ZeroByte);
				bq.push_back(anxb_pkg::CodeByte);
				plen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
				repeat (plen)
					bq.push_back(pick_payload_byte());
			end
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(2, 3))
					bq.push_back(anxb_pkg::ZeroByte);
				bq.push_back(anxb_pkg::CodeByte);
			end
		end else begin
			repeat ($urandom_range(1, 10))
				bq.push_back(pick_payload_byte());
		end
		// Now and then the timestamp changes partway through the buffer.
		shift_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, bq.size() - 1)
			: bq.size();
		for (int i = 0; i < bq.size(); i++)
			queue_byte(bq[i], (i >= shift_at) ? ts_late : ts, i == bq.size() - 1);
		buffers_built++;
	endtask

	// ------------------------------------------------------------------
	// Sender. It offers words in bursts of random length with random gaps
	// between bursts, and holds each word until the core takes it.
	// ------------------------------------------------------------------
	bit feed_go = 1'b0;
	bit byte_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin : feed_drive
		logic               next_valid;
		anxb_pkg::in_word_t next_word;
		next_valid = byte_valid;
		next_word = byte_word;
		if (feed_go && (!byte_valid || byte_taken)) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (feed_q.size() > 0
					&& !(feed_q[0].wait_drain && nal_expect_q.size() > 0)) begin
				next_valid = 1'b1;
				next_word = feed_q[0].w;
				void'(feed_q.pop_front());
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					// About a third of the bursts follow on with no gap at all.
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end
		end
		byte_valid <= next_valid;
		byte_word <= next_word;
	end

	// ------------------------------------------------------------------
	// Receiver. It stalls on a pattern that is picked anew at random:
	// never, sparse, alternating or dense. Once, after enough nal
	// words, it holds off for a long stretch while the sender keeps
	// offering, so that the result buffer fills and byte_stall rises.
	// ------------------------------------------------------------------
	int  nal_seen = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	int  pattern_kind = 0;
	int  pattern_left = 0;

	always @(negedge clk) begin : nal_stall_drive
		logic next_stall;
		next_stall = 1'b0;
		if (hold_left > 0) begin
			hold_left--;
			next_stall = 1'b1;
		end else if (!hold_done && nal_seen >= HoldOffAfter && byte_valid) begin
			hold_left = HoldOffCycles - 1;
			hold_done = 1'b1;
			next_stall = 1'b1;
		end else begin
			if (pattern_left == 0) begin
				pattern_kind = $urandom_range(0, 3);
				pattern_left = $urandom_range(10, 60);
			end
			pattern_left--;
			case (pattern_kind)
				0: next_stall = 1'b0;
				1: next_stall = ($urandom_range(0, 9) < 3);
				2: next_stall = ~nal_stall;
				default: next_stall = ($urandom_range(0, 9) < 7);
			endcase
		end
		nal_stall <= next_stall;
	end

	// ------------------------------------------------------------------
	// Checker. On each rising edge the nal word taken there is compared
	// with the oldest expected word, and then a byte word taken at the
	// same edge is run through the scan model. A byte cannot produce a
	// nal word at the edge that takes it, so this order is safe.
	// ------------------------------------------------------------------
	int errors = 0;
	int empty_seen = 0;
	int starts_seen = 0;
	int bytes_fed = 0;

	always @(posedge clk) begin : check_and_predict
		anxb_pkg::out_word_t want;
		byte_taken <= arst_n && byte_valid && !byte_stall;
		if (arst_n && nal_valid && !nal_stall) begin
			nal_seen++;
			if (nal_word.empty_nal === 1'b1)
				empty_seen++;
			if (nal_word.first_of_nal === 1'b1)
				starts_seen++;
			if (nal_expect_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected nal word byte=%h first=%b last=%b empty=%b pts=%h",
					$time, nal_word.nal_byte, nal_word.first_of_nal,
					nal_word.last_of_nal, nal_word.empty_nal, nal_word.nal_pts);
			end else begin
				want = nal_expect_q.pop_front();
				if (nal_word !== want) begin
					errors++;
					$display("%0t: nal word mismatch", $time);
					$display("  expected byte=%h first=%b last=%b empty=%b pts=%h",
						want.nal_byte, want.first_of_nal, want.last_of_nal,
						want.empty_nal, want.nal_pts);
					$display("  actual   byte=%h first=%b last=%b empty=%b pts=%h",
						nal_word.nal_byte, nal_word.first_of_nal, nal_word.last_of_nal,
						nal_word.empty_nal, nal_word.nal_pts);
				end
			end
		end
		if (arst_n && byte_valid && !byte_stall) begin
			bytes_fed++;
			predict_nal_words(byte_word);
		end
	end

	// Watchdog: a long run of cycles in which no word moves means the
	// core has locked up.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (nal_valid && !nal_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("%0t: no word moved for %0d cycles", $time, IdleLimit);
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Run control.
	// ------------------------------------------------------------------
	initial begin
		logic [63:0] ts_a;
		logic [63:0] ts_b;
		bit          mid_drain;
		ts_a = '1;
		ts_b = 64'h0123_4567_89AB_CDEF;
		mid_drain = 1'b0;

		// Directed buffers. The first has no start code at all, with a lone
		// 01 after a single zero; none of it may come out.
		queue_byte(anxb_pkg::CodeByte, '0, 1'b0);
		queue_byte(anxb_pkg::ZeroByte, '0, 1'b0);
		queue_byte(anxb_pkg::CodeByte, '0, 1'b0);
		queue_byte(8'hFF, '0, 1'b1);
		// The second opens with a 4-byte code, then a 3-byte code, then a
		// code straight after it (an empty NAL in the middle). The payload
		// 80 arrives under a new timestamp but keeps the one its code
		// latched; four zeros before 01 put one zero into the payload and
		// form a 4-byte code that latches the new timestamp. It ends on a
		// trailing code that opens nothing.
		queue_byte(anxb_pkg::ZeroByte, ts_a, 1'b0);
		queue_byte(anxb_pkg::ZeroByte, ts_a, 1'b0);
		queue_byte(anxb_pkg::ZeroByte, ts_a, 1'b0);
		queue_byte(anxb_pkg::CodeByte, ts_a, 1'b0);
		queue_byte(8'hFF, ts_a, 1'b0);
		queue_byte(anxb_pkg::ZeroByte, ts_a, 1'b0);
		queue_byte(anxb_pkg::ZeroByte, ts_a, 1'b0);
		queue_byte(anxb_pkg::CodeByte, ts_a, 1'b0);
		queue_byte(anxb_pkg::ZeroByte, ts_a, 1'b0);
		queue_byte(anxb_pkg::ZeroByte, ts_a, 1'b0);
		queue_byte(anxb_pkg::CodeByte, ts_a, 1'b0);
		queue_byte(8'h80, ts_b, 1'b0);
		repeat (4)
			queue_byte(anxb_pkg::ZeroByte, ts_b, 1'b0);
		queue_byte(anxb_pkg::CodeByte, ts_b, 1'b0);
		queue_byte(8'h7F, ts_b, 1'b0);
		queue_byte(anxb_pkg::ZeroByte, ts_b, 1'b0);
		queue_byte(anxb_pkg::ZeroByte, ts_b, 1'b0);
		queue_byte(anxb_pkg::CodeByte, ts_b, 1'b1);
		buffers_built = 2;

		// The random part starts from an empty pipeline, and the sender
		// pauses once more partway through until everything has drained.
		drain_next = 1'b1;
		while (feed_q.size() < 215) begin
			if (!mid_drain && feed_q.size() >= 120) begin
				drain_next = 1'b1;
				mid_drain = 1'b1;
			end
			build_random_buffer();
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		feed_go = 1'b1;

		while (feed_q.size() > 0 || byte_valid)
			@(posedge clk);
		while (nal_expect_q.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);

		if (nal_expect_q.size() > 0) begin
			errors++;
			$display("%0t: %0d expected nal words never came", $time, nal_expect_q.size());
		end
		$display("Fed %0d byte words in %0d buffers; checked %0d nal words.",
			bytes_fed, buffers_built, nal_seen);
		$display("Those held %0d NAL starts and %0d empty markers; %0d errors.",
			starts_seen, empty_seen, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/anxb_pkg.sv
src/anxb_scan.sv
src/annexb_nal_unit_splitter_core.sv
tb/tb.sv
